/* hw/rtl/weighted_color_accumulator_defines.svh */
// assertion macros used by the port-level checker file
`ifndef WEIGHTED_COLOR_ACCUMULATOR_DEFINES_SVH
`define WEIGHTED_COLOR_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WCA_ASSERT_NOW(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("implication failed");

// next-cycle implication, disabled while reset is asserted
`define WCA_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("next-cycle implication failed");

`endif

/* hw/rtl/wca_pkg.sv */
// shared constants, codes and types of the weighted color accumulator
package wca_pkg;
	localparam int DEF_TABLE_ENTRIES = 4096;
	localparam int IDX_W   = 12;                  // entry_index field width
	localparam int PTR_W   = 17;                  // holds any table size up to 65536
	localparam int CH_W    = 8;                   // one color channel / weight
	localparam int LANES   = 3;                   // red, green, blue
	localparam int WORD_W  = CH_W * (LANES + 1);  // weight plus three means
	localparam int NUM_W   = 2 * CH_W + 1;        // sum of two byte products
	localparam int DIV_W   = CH_W + 1;            // divisor up to 256
	localparam int QUO_W   = CH_W;
	localparam int CNT_W   = $clog2(QUO_W + 1);
	localparam int ACT_W   = 2;
	localparam int S_TDATA_W = ((IDX_W + CH_W * 4 + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WEIGHTED = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UNIT     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

	typedef logic [LANES-1:0][CH_W-1:0] chan_vec_t;

	// what the control path hands to the merge stage
	typedef struct packed {
		logic [CH_W-1:0] weight;
		chan_vec_t       means;
		logic            rejected;
		logic            use_lanes;
	} merge_ctl_t;
endpackage

/* hw/rtl/wca_div_lane.sv */
// one channel lane: weighted sum and restoring radix-2 divide, one quotient bit a cycle
module wca_div_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wca_pkg::CH_W-1:0]    prev_w,
	input  logic [wca_pkg::CH_W-1:0]    mean,
	input  logic [wca_pkg::CH_W-1:0]    w,
	input  logic [wca_pkg::CH_W-1:0]    sample,
	input  logic [wca_pkg::DIV_W-1:0]   divisor,
	output logic                        busy,
	output logic [wca_pkg::QUO_W-1:0]   quotient
);
	logic [wca_pkg::NUM_W-1:0] rem_q;
	logic [wca_pkg::NUM_W-1:0] dv_q;
	logic [wca_pkg::QUO_W-1:0] quo_q;
	logic [wca_pkg::CNT_W-1:0] cnt_q;
	logic [wca_pkg::NUM_W-1:0] numer;
	logic [wca_pkg::NUM_W-1:0] dv_start;
	logic                      fits;

	// operands widened first so both products keep their full width
	assign numer = wca_pkg::NUM_W'(prev_w) * wca_pkg::NUM_W'(mean)
		+ wca_pkg::NUM_W'(w) * wca_pkg::NUM_W'(sample);
	// divisor aligned to the top quotient bit
	assign dv_start = wca_pkg::NUM_W'({divisor, {(wca_pkg::QUO_W-1){1'b0}}});
	assign fits = (rem_q >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= wca_pkg::CNT_W'(wca_pkg::QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			dv_q  <= dv_start;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= rem_q - dv_q;
			end
			quo_q <= {quo_q[wca_pkg::QUO_W-2:0], fits};
			dv_q  <= dv_q >> 1;
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;
endmodule

/* hw/rtl/wca_merge.sv */
// merge stage: combines lane quotients into the entry word and holds the output register
module wca_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  wca_pkg::merge_ctl_t          ctl,
	input  wca_pkg::chan_vec_t           lane_quo,
	output logic [wca_pkg::WORD_W-1:0]   merged_word,
	output logic                         free,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [wca_pkg::WORD_W-1:0]   m_tdata,
	output logic [0:0]                   m_tuser
);
	logic                       valid_q;
	logic [wca_pkg::WORD_W-1:0] data_q;
	logic                       rej_q;
	wca_pkg::chan_vec_t         means;

	assign means       = ctl.use_lanes ? lane_quo : ctl.means;
	assign merged_word = {means, ctl.weight};
	assign free        = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= merged_word;
			rej_q  <= ctl.rejected;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = rej_q;
endmodule

/* hw/rtl/weighted_color_accumulator.sv */
// top level: accumulator table, control sequencer, three divider lanes and merge stage
// each item runs through setup, the divide, a done check and the push into the output register
// clear, refused, out-of-range and no-op actions skip the divide and go from setup to the push
// input is closed from a transfer until the push; the next item is taken once the sequencer is idle
// a new item is taken while the previous result still waits; a stalled output holds the push
// arst_n clears control state only; table contents are undefined until an entry is cleared
module weighted_color_accumulator #(
	parameter int TABLE_ENTRIES = wca_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entry_index[11:0], weight[19:12], sample_red[27:20],
	// sample_green[35:28], sample_blue[43:36], zero pad[47:44]
	input  logic [wca_pkg::S_TDATA_W-1:0]     s_tdata,
	// action[1:0]
	input  logic [wca_pkg::ACT_W-1:0]         s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// total_weight[7:0], mean_red[15:8], mean_green[23:16], mean_blue[31:24]
	output logic [wca_pkg::WORD_W-1:0]        m_tdata,
	// rejected[0]
	output logic [0:0]                        m_tuser
);
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = wca_pkg::CH_W;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CALC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// captured item
	logic [wca_pkg::ACT_W-1:0]  act_q;
	logic [AW-1:0]              addr_q;
	logic                       in_range_q;
	logic [CW-1:0]              w_q;
	wca_pkg::chan_vec_t         smp_q;
	logic [wca_pkg::WORD_W-1:0] rd_q;

	// table storage
	logic [wca_pkg::WORD_W-1:0] table_mem [TABLE_ENTRIES];

	logic                       in_xfer;
	logic [wca_pkg::PTR_W-1:0]  idx_ext;
	logic [AW-1:0]              addr_in;

	// setup decisions
	wca_pkg::merge_ctl_t        ctl_d;
	wca_pkg::merge_ctl_t        ctl_q;
	logic                       wr_d;
	logic                       wr_q;
	logic [CW-1:0]              prev_w;
	logic [CW-1:0]              w_eff;
	logic [CW-1:0]              lane_w;
	logic [wca_pkg::DIV_W-1:0]  sum_w;
	logic [wca_pkg::DIV_W-1:0]  unit_w;
	logic [wca_pkg::DIV_W-1:0]  lane_div;
	wca_pkg::chan_vec_t         rd_means;
	logic                       lane_start;

	// lanes and merge
	logic [wca_pkg::LANES-1:0]  lane_busy;
	wca_pkg::chan_vec_t         lane_quo;
	logic [wca_pkg::WORD_W-1:0] merged_word;
	logic                       out_free;
	logic                       push;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign idx_ext  = wca_pkg::PTR_W'(s_tdata[wca_pkg::IDX_W-1:0]);
	assign addr_in  = idx_ext[AW-1:0];

	// capture the item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q      <= s_tuser;
			addr_q     <= addr_in;
			in_range_q <= (idx_ext < wca_pkg::PTR_W'(TABLE_ENTRIES));
			w_q        <= s_tdata[wca_pkg::IDX_W +: CW];
			smp_q      <= s_tdata[wca_pkg::IDX_W + CW +: CW * wca_pkg::LANES];
		end
	end

	// table: registered read on transfer, write back in the push cycle
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_q <= table_mem[addr_in];
		end
		if (push && wr_q) begin
			table_mem[addr_q] <= merged_word;
		end
	end

	assign prev_w   = rd_q[CW-1:0];
	assign rd_means = rd_q[wca_pkg::WORD_W-1:CW];
	// weight zero counts as one
	assign w_eff    = (w_q == '0) ? CW'(1) : w_q;
	assign sum_w    = {1'b0, prev_w} + {1'b0, w_eff};
	// unit add: weight wraps, divisor reaches 256
	assign unit_w   = {1'b0, prev_w} + wca_pkg::DIV_W'(1);

	always_comb begin
		ctl_d    = '0;
		wr_d     = 1'b0;
		lane_w   = w_eff;
		lane_div = sum_w;
		unique case (act_q)
			wca_pkg::ACT_CLEAR: begin
				wr_d = 1'b1;
			end
			wca_pkg::ACT_WEIGHTED: begin
				if (sum_w[CW]) begin
					// overflow: entry stays as it is
					ctl_d.weight   = prev_w;
					ctl_d.means    = rd_means;
					ctl_d.rejected = 1'b1;
				end else begin
					ctl_d.weight    = sum_w[CW-1:0];
					ctl_d.use_lanes = 1'b1;
					wr_d            = 1'b1;
				end
			end
			wca_pkg::ACT_UNIT: begin
				ctl_d.weight    = unit_w[CW-1:0];
				ctl_d.use_lanes = 1'b1;
				lane_w          = CW'(1);
				lane_div        = unit_w;
				wr_d            = 1'b1;
			end
			wca_pkg::ACT_NONE: begin
				ctl_d.weight = prev_w;
				ctl_d.means  = rd_means;
			end
			default: begin
				ctl_d = '0;
			end
		endcase
		// index beyond the table: all-zero result, no write
		if (!in_range_q) begin
			ctl_d = '0;
			wr_d  = 1'b0;
		end
	end

	assign lane_start = (state_q == S_CALC) && ctl_d.use_lanes;

	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			ctl_q <= ctl_d;
			wr_q  <= wr_d;
		end
	end

	// one divider lane per color channel
	for (genvar g = 0; g < wca_pkg::LANES; g++) begin : g_lane
		wca_div_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (lane_start),
			.prev_w   (prev_w),
			.mean     (rd_means[g]),
			.w        (lane_w),
			.sample   (smp_q[g]),
			.divisor  (lane_div),
			.busy     (lane_busy[g]),
			.quotient (lane_quo[g])
		);
	end

	assign push = (state_q == S_PUSH) && out_free;

	wca_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (push),
		.ctl         (ctl_q),
		.lane_quo    (lane_quo),
		.merged_word (merged_word),
		.free        (out_free),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				state_d = ctl_d.use_lanes ? S_DIV : S_PUSH;
			end
			S_DIV: begin
				if (lane_busy == '0) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* hw/rtl/wca_checker.sv */
// port-level checks of the weighted color accumulator, bound to the top level
`include "weighted_color_accumulator_defines.svh"

module wca_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [wca_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [wca_pkg::ACT_W-1:0]     s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [wca_pkg::WORD_W-1:0]    m_tdata,
	input logic [0:0]                    m_tuser
);
	// one item at a time: input closes right after a transfer
	`WCA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a refused add always leaves a nonzero weight behind
	`WCA_ASSERT_NOW(a_rej_weight, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[7:0] != 8'd0)

	// a stalled result stays offered
	`WCA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// a stalled result keeps its payload
	`WCA_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tuser))
endmodule

bind weighted_color_accumulator wca_checker u_wca_checker (.*);

/* tb/sv/color_average_checker.sv */
// checker for the weighted color accumulator: mirrors the entry table and compares every result
module color_average_checker #(
	parameter int ENTRIES = wca_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [wca_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [wca_pkg::ACT_W-1:0]     s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [wca_pkg::WORD_W-1:0]    m_tdata,
	input  logic [0:0]                    m_tuser,
	output int                            failures,
	output int                            pending,
	output int                            checked,
	output int                            refusals,
	output int                            wraps
);
	import wca_pkg::*;

	// same layout as m_tdata: weight in the low byte
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] weight;
	} color_entry_t;

	typedef struct packed {
		color_entry_t entry;
		logic         rejected;
	} entry_result_t;

	color_entry_t  entry_store [ENTRIES];
	entry_result_t expected_entries [$];

	function automatic logic [7:0] blend_mean(logic [7:0] prev_w, logic [7:0] mean,
			int unsigned wt, logic [7:0] smp, int unsigned divisor);
		int unsigned num;
		num = int'(prev_w) * int'(mean) + wt * int'(smp);
		return 8'(num / divisor);
	endfunction

	// divisor runs from 1 to 256, the new weight is its low byte
	function automatic color_entry_t fold_sample(color_entry_t old, int unsigned wt,
			int unsigned divisor, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		color_entry_t upd;
		upd.weight = 8'(divisor);
		upd.red    = blend_mean(old.weight, old.red, wt, r, divisor);
		upd.green  = blend_mean(old.weight, old.green, wt, g, divisor);
		upd.blue   = blend_mean(old.weight, old.blue, wt, b, divisor);
		return upd;
	endfunction

	function automatic entry_result_t predict_result(logic [ACT_W-1:0] act, logic [11:0] idx,
			logic [7:0] w, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		entry_result_t res;
		color_entry_t  cur;
		int unsigned   wt;
		int unsigned   sum;
		res = '0;
		if (idx >= ENTRIES) begin
			return res;
		end
		cur = entry_store[idx];
		case (act)
			ACT_CLEAR: begin
				cur = '0;
			end
			ACT_WEIGHTED: begin
				wt = (w == 8'd0) ? 1 : int'(w);
				sum = int'(cur.weight) + wt;
				if (sum > 255) begin
					res.rejected = 1'b1;
					refusals++;
				end else begin
					cur = fold_sample(cur, wt, sum, r, g, b);
				end
			end
			ACT_UNIT: begin
				if (cur.weight == 8'hFF) begin
					wraps++;
				end
				cur = fold_sample(cur, 1, int'(cur.weight) + 1, r, g, b);
			end
			default: begin
			end
		endcase
		entry_store[idx] = cur;
		res.entry = cur;
		return res;
	endfunction

	task automatic compare_field(string what, logic [7:0] want_v, logic [7:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		entry_result_t want;
		color_entry_t  got;
		if (!arst_n) begin
			expected_entries.delete();
			failures = 0;
			pending  = 0;
			checked  = 0;
			refusals = 0;
			wraps    = 0;
		end else begin
			// results leave only after their action has passed the sequencer and the output register, so pop before push
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_entries.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h rejected %b",
						$time, m_tdata, m_tuser);
					failures++;
				end else begin
					want = expected_entries.pop_front();
					compare_field("total_weight", want.entry.weight, got.weight);
					compare_field("mean_red", want.entry.red, got.red);
					compare_field("mean_green", want.entry.green, got.green);
					compare_field("mean_blue", want.entry.blue, got.blue);
					compare_field("rejected", {7'd0, want.rejected}, {7'd0, m_tuser});
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_entries.push_back(predict_result(s_tuser, s_tdata[11:0],
					s_tdata[19:12], s_tdata[27:20], s_tdata[35:28], s_tdata[43:36]));
			end
			pending = expected_entries.size();
		end
	end
endmodule

/* tb/sv/tb_weighted_color_accumulator.sv */
// testbench top: drives accumulator actions, paces the result side and reports the verdict
module tb_weighted_color_accumulator;
	import wca_pkg::*;

	localparam int IDLE_LIMIT     = 1000;  // cycles without any transfer before giving up
	localparam int SQUEEZE_START  = 400;   // receiver cycle at which the long hold-off begins
	localparam int SQUEEZE_CYCLES = 300;
	localparam int RANDOM_ITEMS   = 830;
	localparam int LIVE_MAX       = 32;    // working set of cleared entries
	localparam int DRAIN_CYCLES   = 24;    // wait after draining, for any stray result

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [ACT_W-1:0]     s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [WORD_W-1:0]    m_tdata;
	logic [0:0]           m_tuser;

	int failures;
	int pending;
	int checked;
	int refusals;
	int wraps;
	int actions_sent;
	int idle_cycles;

	// entries that have been cleared at least once; only these are ever read
	logic [11:0] live_entries [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	weighted_color_accumulator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	color_average_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending),
		.checked  (checked),
		.refusals (refusals),
		.wraps    (wraps)
	);

	// watchdog: a hang shows up as a long run of cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// result side: alternating ready and stall stretches, plus one long hold-off
	// that lets the block fill up and push back on the input side
	initial begin : result_pacer
		int cycles_since_reset;
		int phase_left;
		bit ready_phase;
		m_tready = 1'b0;
		cycles_since_reset = 0;
		phase_left = 0;
		ready_phase = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycles_since_reset++;
			if (cycles_since_reset >= SQUEEZE_START &&
					cycles_since_reset < SQUEEZE_START + SQUEEZE_CYCLES) begin
				m_tready <= 1'b0;
				phase_left = 0;
				ready_phase = 1'b0;
			end else begin
				if (phase_left == 0) begin
					ready_phase = !ready_phase;
					if (ready_phase) begin
						// now and then a long stretch with no stall at all
						phase_left = ($urandom_range(0, 9) == 0) ?
							$urandom_range(100, 200) : $urandom_range(1, 20);
					end else begin
						phase_left = ($urandom_range(0, 9) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 3);
					end
				end
				m_tready <= ready_phase;
				phase_left--;
			end
		end
	end

	// sample byte biased toward the extremes
	function automatic logic [7:0] sample_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return 8'h00;
		end else if (roll == 1) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly small weights so entries build up over many adds, some large ones to hit refusal
	function automatic logic [7:0] weight_byte();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			return 8'($urandom_range(0, 7));
		end else if (roll < 70) begin
			return 8'($urandom_range(8, 64));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [11:0] pick_live();
		return live_entries[$urandom_range(0, live_entries.size() - 1)];
	endfunction

	function automatic void remember_entry(logic [11:0] idx);
		foreach (live_entries[i]) begin
			if (live_entries[i] == idx) begin
				return;
			end
		end
		if (live_entries.size() < LIVE_MAX) begin
			live_entries.push_back(idx);
		end else begin
			live_entries[$urandom_range(0, LIVE_MAX - 1)] = idx;
		end
	endfunction

	// one input transfer, preceded by a random gap; called and returns at a falling edge
	task automatic send_action(input logic [ACT_W-1:0] act, input logic [11:0] idx,
			input logic [7:0] w, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap = (roll < 60) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({b, g, r, w, idx});
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		actions_sent++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [11:0]      idx;
		logic [ACT_W-1:0] act;
		int               roll;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_CLEAR;
		arst_n = 1'b0;
		actions_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corner entries, zero weight, full weight, refusal and weight wrap
		send_action(ACT_CLEAR, 12'h000, 8'h00, 8'h00, 8'h00, 8'h00);
		remember_entry(12'h000);
		send_action(ACT_CLEAR, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		remember_entry(12'hFFF);
		send_action(ACT_NONE, 12'h000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_action(ACT_WEIGHTED, 12'h000, 8'h00, 8'hFF, 8'hFF, 8'hFF);  // zero weight counts as one
		send_action(ACT_WEIGHTED, 12'h000, 8'd254, 8'h00, 8'h00, 8'h00); // fills up to 255
		send_action(ACT_WEIGHTED, 12'h000, 8'h00, 8'h12, 8'h34, 8'h56);  // refused at 255
		send_action(ACT_WEIGHTED, 12'h000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // refused, max weight
		send_action(ACT_UNIT, 12'h000, 8'h00, 8'hFF, 8'h00, 8'h80);      // wraps, divides by 256
		send_action(ACT_UNIT, 12'h000, 8'hFF, 8'h01, 8'h02, 8'h03);      // from zero weight
		send_action(ACT_WEIGHTED, 12'hFFF, 8'hFF, 8'hAA, 8'h55, 8'hFF);
		send_action(ACT_WEIGHTED, 12'hFFF, 8'h01, 8'h00, 8'h00, 8'h00);
		send_action(ACT_NONE, 12'hFFF, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_UNIT, 12'hFFF, 8'h00, 8'h00, 8'hFF, 8'h00);
		send_action(ACT_CLEAR, 12'hAAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
		remember_entry(12'hAAA);
		send_action(ACT_CLEAR, 12'h555, 8'hAA, 8'h55, 8'hAA, 8'h55);
		remember_entry(12'h555);
		send_action(ACT_WEIGHTED, 12'h555, 8'd128, 8'h80, 8'h7F, 8'h01);
		send_action(ACT_WEIGHTED, 12'h555, 8'd128, 8'h00, 8'hFF, 8'h00); // sum 256, refused
		send_action(ACT_WEIGHTED, 12'h555, 8'd127, 8'hFF, 8'h00, 8'h80); // lands on 255
		send_action(ACT_UNIT, 12'hAAA, 8'h00, 8'h55, 8'hAA, 8'hFF);
		send_action(ACT_WEIGHTED, 12'hAAA, 8'h00, 8'h00, 8'hFF, 8'h00);
		send_action(ACT_CLEAR, 12'hFFF, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_NONE, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

		// random: clears open new entries, the rest accumulate into or read cleared ones
		repeat (RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				idx = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : pick_live();
				send_action(ACT_CLEAR, idx, weight_byte(), sample_byte(), sample_byte(),
					sample_byte());
				remember_entry(idx);
			end else begin
				if (roll < 16) begin
					act = ACT_NONE;
				end else if (roll < 62) begin
					act = ACT_WEIGHTED;
				end else begin
					act = ACT_UNIT;
				end
				send_action(act, pick_live(), weight_byte(), sample_byte(), sample_byte(),
					sample_byte());
			end
		end
		s_tvalid <= 1'b0;

		// drain, then give the block time to show any stray result
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d actions (clears, weighted and unit adds, plain reads)",
			actions_sent);
		$display("%0d results checked, refused weighted adds: %0d, weight wraps on unit add: %0d",
			checked, refusals, wraps);
		if (failures == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
